FILE: sv/padec_pkg.sv
// Shared types and constants for the palette animation frame decoder.
// No dependencies; used by the decoder top level and its port checker.
`default_nettype none

package padec_pkg;

  // Palette store depth and its address width
  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  // Input actions
  localparam logic [1:0] ACT_PALETTE = 2'd0;
  localparam logic [1:0] ACT_DATA    = 2'd1;
  localparam logic [1:0] ACT_END     = 2'd2;
  localparam logic [1:0] ACT_RESTART = 2'd3;

  // Result events
  localparam logic [2:0] EV_PIXEL  = 3'd0;
  localparam logic [2:0] EV_SHOWN  = 3'd1;
  localparam logic [2:0] EV_DELAY  = 3'd2;
  localparam logic [2:0] EV_FADE   = 3'd3;
  localparam logic [2:0] EV_REPEAT = 3'd4;
  localparam logic [2:0] EV_HALTED = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_PALETTE_SIZE = 2'd0;
  localparam logic [1:0] CFG_PIXEL_COUNT  = 2'd1;
  localparam logic [1:0] CFG_LOOP_COUNT   = 2'd2;
  localparam logic [1:0] CFG_INTERVAL     = 2'd3;

  // Frame type bytes
  localparam logic [7:0] TYPE_I = 8'h49;
  localparam logic [7:0] TYPE_P = 8'h50;
  localparam logic [7:0] TYPE_D = 8'h44;
  localparam logic [7:0] TYPE_F = 8'h46;

  // Displays with more pixels than this use 16-bit P-frame addresses
  localparam logic [15:0] SHORT_ADDR_LIMIT = 16'd256;

  localparam logic [15:0] INTERVAL_RESET = 16'd83;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic [7:0] palette_slot;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] pixel_index;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [15:0] duration_ms;
    logic        last;
  } out_item_t;

endpackage

`default_nettype wire

FILE: sv/palette_animation_frame_decoder_unit.sv
// Palette animation frame decoder: top level with decode state, palette store
// and the two-stage result path. Depends on padec_pkg.
`default_nettype none

// How to use it:
//  - Input channel (in_valid / in_stall / in_data): one transaction per stream
//    event: a palette write, one frame data byte, end of frame data, or restart.
//  - Result channel (out_valid / out_stall / out_data): pixel writes, frame
//    shown, delay, fade, repeat and halted events; last marks the final result
//    of one input transaction. Transactions that produce nothing emit nothing.
//  - Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
//    ready; write only while the block is idle.
//  - Result path: the results of an accepted transaction pass through the
//    decode register, then the output register.
//  - Throughput: one input transaction per cycle without output stall. A
//    transaction with two results sends them out in turn, so in_stall may
//    rise for one cycle then. The palette store has one write and one
//    registered read port; the read for a pixel happens at the accepting edge.
//  - Output stall: the output register and the decode register fill, then
//    in_stall rises; nothing is dropped.
//  - Reset: decode state and halt flag clear, the loop counter goes to one;
//    config registers go to their defaults. The palette is not cleared and must be loaded.
module palette_animation_frame_decoder_unit (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  padec_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output padec_pkg::out_item_t out_data,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [1:0]           cfg_index,
  input  wire  [15:0]          cfg_data
);

  typedef enum logic [2:0] {
    PH_TYPE, PH_HI, PH_LO, PH_ICOL, PH_PADDR, PH_PADDR_LO, PH_PCOL
  } phase_t;

  typedef enum logic [1:0] {KIND_I, KIND_P, KIND_D, KIND_F} kind_t;

  // One decoded result before the palette color is attached
  typedef struct packed {
    logic [2:0]  ev;
    logic [15:0] pix;
    logic [15:0] dur;
  } res_desc_t;

  // Config registers
  logic [8:0]  palette_size_r;
  logic [15:0] pixel_count_r;
  logic [15:0] loop_count_r;
  logic [15:0] interval_r;

  // Decode state
  phase_t      phase_r, phase_nxt;
  kind_t       kind_r, kind_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [15:0] cursor_r, cursor_nxt;
  logic [15:0] loops_r, loops_nxt;
  logic        halted_r, halted_nxt;

  // Decode outputs for the current transaction
  res_desc_t   res0, res1;
  logic        res_any, res_two;

  // Decode register and palette read data
  logic        s1_valid_r;
  logic        s1_two_r;
  res_desc_t   s1_res0_r, s1_res1_r;
  logic [23:0] rd_r;
  logic [23:0] pal_mem [padec_pkg::PALETTE_DEPTH];

  // Output register and second-result holding register
  logic                 out_valid_r;
  padec_pkg::out_item_t out_r;
  logic                 pend_valid_r;
  padec_pkg::out_item_t pend_r;
  padec_pkg::out_item_t first_item, second_item;

  logic accept, out_fire, out_free, s1_move;

  // ---------------------------------------------------------------- handshakes
  assign out_fire  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || out_fire;
  // Decode register moves on only once the second result of the previous pair is out
  assign s1_move   = s1_valid_r && out_free && !pend_valid_r;
  assign in_stall  = s1_valid_r && !s1_move;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_size_r <= 9'd0;
      pixel_count_r  <= 16'd0;
      loop_count_r   <= 16'd0;
      interval_r     <= padec_pkg::INTERVAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        padec_pkg::CFG_PALETTE_SIZE: palette_size_r <= cfg_data[8:0];
        padec_pkg::CFG_PIXEL_COUNT:  pixel_count_r  <= cfg_data;
        padec_pkg::CFG_LOOP_COUNT:   loop_count_r   <= cfg_data;
        padec_pkg::CFG_INTERVAL:     interval_r     <= cfg_data;
      endcase
    end
  end

  // ---------------------------------------------------------------- decode
  always_comb begin
    logic [15:0] w;
    logic [15:0] lr;
    logic [15:0] left_dec;
    logic        pix_ok;
    logic [7:0]  b;

    b        = in_data.data_byte;
    w        = {hi_r, b};
    left_dec = left_r - 16'd1;
    pix_ok   = ({1'b0, b} < palette_size_r) &&
               ({1'b0, b} < 9'(padec_pkg::PALETTE_DEPTH));
    lr       = loops_r;

    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    left_nxt   = left_r;
    hi_nxt     = hi_r;
    cursor_nxt = cursor_r;
    loops_nxt  = loops_r;
    halted_nxt = halted_r;
    res0       = '0;
    res1       = '0;
    res_any    = 1'b0;
    res_two    = 1'b0;

    unique case (in_data.action)
      padec_pkg::ACT_PALETTE: begin
        // store write handled with the memory
      end
      padec_pkg::ACT_RESTART: begin
        loops_nxt  = (loop_count_r != 16'd0) ? loop_count_r : 16'd1;
        phase_nxt  = PH_TYPE;
        kind_nxt   = KIND_I;
        left_nxt   = 16'd0;
        hi_nxt     = 8'd0;
        cursor_nxt = 16'd0;
        halted_nxt = 1'b0;
      end
      padec_pkg::ACT_DATA: begin
        if (!halted_r) begin
          unique case (phase_r)
            PH_TYPE: begin
              phase_nxt = PH_HI;
              priority if (b == padec_pkg::TYPE_I) kind_nxt = KIND_I;
              else if (b == padec_pkg::TYPE_P) kind_nxt = KIND_P;
              else if (b == padec_pkg::TYPE_D) kind_nxt = KIND_D;
              else if (b == padec_pkg::TYPE_F) kind_nxt = KIND_F;
              else begin
                halted_nxt = 1'b1;
                phase_nxt  = PH_TYPE;
                res0.ev    = padec_pkg::EV_HALTED;
                res_any    = 1'b1;
              end
            end
            PH_HI: begin
              hi_nxt    = b;
              phase_nxt = PH_LO;
            end
            PH_LO: begin
              if (kind_r == KIND_I || kind_r == KIND_P) begin
                left_nxt   = w;
                cursor_nxt = 16'd0;
                if (w == 16'd0) begin
                  phase_nxt = PH_TYPE;
                  res0.ev   = padec_pkg::EV_SHOWN;
                  res0.dur  = interval_r;
                  res_any   = 1'b1;
                end else begin
                  phase_nxt = (kind_r == KIND_I) ? PH_ICOL : PH_PADDR;
                end
              end else if (w == 16'd0) begin
                halted_nxt = 1'b1;
                phase_nxt  = PH_TYPE;
                res0.ev    = padec_pkg::EV_HALTED;
                res_any    = 1'b1;
              end else begin
                phase_nxt = PH_TYPE;
                res0.ev   = (kind_r == KIND_D) ? padec_pkg::EV_DELAY : padec_pkg::EV_FADE;
                res0.dur  = w;
                res_any   = 1'b1;
              end
            end
            PH_ICOL, PH_PCOL: begin
              left_nxt = left_dec;
              if (phase_r == PH_ICOL) begin
                cursor_nxt = cursor_r + 16'd1;
              end else begin
                phase_nxt = PH_PADDR;
              end
              if (pix_ok) begin
                res0.ev  = padec_pkg::EV_PIXEL;
                res0.pix = cursor_r;
                res_any  = 1'b1;
              end
              if (left_dec == 16'd0) begin
                phase_nxt = PH_TYPE;
                if (pix_ok) begin
                  res1.ev  = padec_pkg::EV_SHOWN;
                  res1.dur = interval_r;
                  res_two  = 1'b1;
                end else begin
                  res0.ev  = padec_pkg::EV_SHOWN;
                  res0.dur = interval_r;
                  res_any  = 1'b1;
                end
              end
            end
            PH_PADDR: begin
              if (pixel_count_r > padec_pkg::SHORT_ADDR_LIMIT) begin
                hi_nxt    = b;
                phase_nxt = PH_PADDR_LO;
              end else begin
                cursor_nxt = {8'd0, b};
                phase_nxt  = PH_PCOL;
              end
            end
            PH_PADDR_LO: begin
              cursor_nxt = w;
              phase_nxt  = PH_PCOL;
            end
            default: phase_nxt = PH_TYPE;
          endcase
        end
      end
      padec_pkg::ACT_END: begin
        if (!halted_r) begin
          if (phase_r != PH_TYPE && (kind_r == KIND_D || kind_r == KIND_F)) begin
            // D or F header cut short: value reads as zero
            halted_nxt = 1'b1;
            phase_nxt  = PH_TYPE;
            res0.ev    = padec_pkg::EV_HALTED;
            res_any    = 1'b1;
          end else begin
            if (loop_count_r != 16'd0 && lr != 16'd0) lr = lr - 16'd1;
            loops_nxt = lr;
            phase_nxt = PH_TYPE;
            res_any   = 1'b1;
            if (phase_r != PH_TYPE) begin
              // partial I or P frame is shown first
              res0.ev  = padec_pkg::EV_SHOWN;
              res0.dur = interval_r;
              res_two  = 1'b1;
              if (lr != 16'd0) begin
                res1.ev = padec_pkg::EV_REPEAT;
              end else begin
                res1.ev    = padec_pkg::EV_HALTED;
                halted_nxt = 1'b1;
              end
            end else if (lr != 16'd0) begin
              res0.ev = padec_pkg::EV_REPEAT;
            end else begin
              res0.ev    = padec_pkg::EV_HALTED;
              halted_nxt = 1'b1;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TYPE;
      kind_r   <= KIND_I;
      left_r   <= 16'd0;
      hi_r     <= 8'd0;
      cursor_r <= 16'd0;
      loops_r  <= 16'd1;
      halted_r <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      kind_r   <= kind_nxt;
      left_r   <= left_nxt;
      hi_r     <= hi_nxt;
      cursor_r <= cursor_nxt;
      loops_r  <= loops_nxt;
      halted_r <= halted_nxt;
    end
  end

  // ---------------------------------------------------------------- palette store
  always_ff @(posedge clk) begin
    if (accept && in_data.action == padec_pkg::ACT_PALETTE &&
        ({1'b0, in_data.palette_slot} < 9'(padec_pkg::PALETTE_DEPTH))) begin
      pal_mem[in_data.palette_slot[padec_pkg::PAL_AW-1:0]] <=
        {in_data.red_in, in_data.green_in, in_data.blue_in};
    end
    if (accept) begin
      rd_r <= pal_mem[in_data.data_byte[padec_pkg::PAL_AW-1:0]];
    end
  end

  // ---------------------------------------------------------------- decode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= res_any || res_two;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_two_r  <= res_two;
      s1_res0_r <= res0;
      s1_res1_r <= res1;
    end
  end

  // ---------------------------------------------------------------- output stage
  // Only the first result of a pair can be a pixel write.
  always_comb begin
    first_item             = '0;
    first_item.event_res   = s1_res0_r.ev;
    first_item.pixel_index = s1_res0_r.pix;
    first_item.duration_ms = s1_res0_r.dur;
    first_item.last        = !s1_two_r;
    if (s1_res0_r.ev == padec_pkg::EV_PIXEL) begin
      first_item.red_out   = rd_r[23:16];
      first_item.green_out = rd_r[15:8];
      first_item.blue_out  = rd_r[7:0];
    end
    second_item             = '0;
    second_item.event_res   = s1_res1_r.ev;
    second_item.duration_ms = s1_res1_r.dur;
    second_item.last        = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (out_free) begin
      if (pend_valid_r) begin
        out_valid_r  <= 1'b1;
        pend_valid_r <= 1'b0;
      end else if (s1_move) begin
        out_valid_r  <= 1'b1;
        pend_valid_r <= s1_two_r;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_valid_r) begin
        out_r <= pend_r;
      end else if (s1_move) begin
        out_r  <= first_item;
        pend_r <= second_item;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/padec_checker.sv
// Port-level checker for the palette animation frame decoder, with its bind.
// Depends on padec_pkg and binds to palette_animation_frame_decoder_unit.
`default_nettype none

module padec_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_stall,
  input padec_pkg::in_item_t  in_data,
  input wire                  out_valid,
  input wire                  out_stall,
  input padec_pkg::out_item_t out_data
);

  // A stalled input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input changed");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A result that is not the last of its transaction is followed right away
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |=> out_valid)
    else $error("second result of a pair missing");

  // Halted always ends the transaction's results
  a_halt_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_res == padec_pkg::EV_HALTED |-> out_data.last)
    else $error("halted result not last");

  // Only pixel writes carry pixel and color; pixel writes carry no duration
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_data.event_res == padec_pkg::EV_PIXEL) ? (out_data.duration_ms == 16'd0) :
      (out_data.pixel_index == 16'd0 && out_data.red_out == 8'd0 &&
       out_data.green_out == 8'd0 && out_data.blue_out == 8'd0))
    else $error("result fields inconsistent with event");

endmodule

bind palette_animation_frame_decoder_unit padec_checker u_padec_checker (.*);

`default_nettype wire
